[rtl/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg
// Shared widths, constants and control structs for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int unsigned MOD_W   = 31;
  localparam int unsigned EXP_W   = 63;
  localparam int unsigned CNT_W   = $clog2(MOD_W);

  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(1000000007);
  localparam logic [MOD_W-1:0] ONE           = MOD_W'(1);

  // request to the shared modular multiplier
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] x;   // addend operand, must be below the modulus
    logic [MOD_W-1:0] y;   // operand scanned one bit a cycle, msb first
  } mme_mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mme_mul_stat_t;

endpackage

[rtl/mme_if.sv]
// ----------------------------------------------------------------------------
// mme_if
// Valid/ready channels of the modular exponentiation block: operand items,
// result items and modulus writes.
// ----------------------------------------------------------------------------
interface mme_req_if;
  logic                      valid;
  logic                      ready;
  logic [mme_pkg::MOD_W-1:0] base_value;
  logic [mme_pkg::EXP_W-1:0] exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mme_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [mme_pkg::MOD_W-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

interface mme_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [mme_pkg::MOD_W-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

[rtl/mme_mulmod.sv]
// ----------------------------------------------------------------------------
// mme_mulmod
// Bit-serial interleaved modular multiplier: one bit of y per cycle,
// r = (2r + y_bit * x) mod m, one step for each of the MOD_W bits of y.
// ----------------------------------------------------------------------------
module mme_mulmod (
  input  logic                      clk,
  input  logic                      rst,
  input  mme_pkg::mme_mul_req_t     req,
  input  logic [mme_pkg::MOD_W-1:0] modulus,
  output mme_pkg::mme_mul_stat_t    stat,
  output logic [mme_pkg::MOD_W-1:0] result
);
  import mme_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [MOD_W-1:0] r;
  logic [MOD_W-1:0] x;
  logic [MOD_W-1:0] y;

  logic [MOD_W+1:0] t;
  logic [MOD_W+2:0] d1;
  logic [MOD_W+2:0] d2;
  logic [MOD_W-1:0] r_next;

  // t stays below 3m, so at most two subtractions of m are needed
  always_comb begin
    t  = {1'b0, r, 1'b0} + {2'b0, (y[MOD_W-1] ? x : '0)};
    d1 = {1'b0, t} - {3'b0, modulus};
    d2 = {1'b0, t} - {2'b0, modulus, 1'b0};
    if (!d2[MOD_W+2]) begin
      r_next = d2[MOD_W-1:0];
    end else if (!d1[MOD_W+2]) begin
      r_next = d1[MOD_W-1:0];
    end else begin
      r_next = t[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MOD_W - 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      r <= '0;
      x <= req.x;
      y <= req.y;
    end else if (busy) begin
      r <= r_next;
      y <= {y[MOD_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = r;

endmodule

[rtl/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply: base_value ^ exponent mod modulus.
// ----------------------------------------------------------------------------
// One item at a time. Every modular product runs on one shared bit-serial
// multiplier. An item costs one product to reduce the base, then for each
// exponent bit up to the highest set one a multiply when the bit is set and
// a squaring unless it is the last bit, with a pass through S_NEXT for each
// bit to step the exponent. A modulus of zero or one yields 0 through S_DONE
// without any product. The next item is taken while a result still waits
// in the output register. Modulus writes are taken at any time and are
// meant to happen only while the block is idle.
module modular_exponentiation (
  input  logic           clk,
  input  logic           rst,
  mme_req_if.sink        req,
  mme_rsp_if.source      rsp,
  mme_cfg_if.sink        cfg
);
  import mme_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_NEXT,
    S_MULT,
    S_SQUARE,
    S_DONE
  } state_t;

  state_t         state;
  logic [MOD_W-1:0] modulus;
  logic [EXP_W-1:0] exp_sr;
  logic [MOD_W-1:0] acc;
  logic [MOD_W-1:0] b;
  logic [MOD_W-1:0] res;
  logic [MOD_W-1:0] out_data;
  logic             out_valid;

  mme_mul_req_t  mreq;
  mme_mul_stat_t mstat;
  logic [MOD_W-1:0] mres;

  logic in_acc;

  assign in_acc    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg.valid) begin
      modulus <= cfg.modulus;
    end
  end

  mme_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .modulus (modulus),
    .stat    (mstat),
    .result  (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mreq.start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      mreq.start <= 1'b0;
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            exp_sr <= req.exponent;
            if (modulus < MOD_W'(2)) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              // base mod m as 1 * base through the multiplier
              mreq.start <= 1'b1;
              mreq.x     <= ONE;
              mreq.y     <= req.base_value;
              state      <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mstat.done) begin
            b     <= mres;
            acc   <= ONE;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (exp_sr == '0) begin
            res   <= acc;
            state <= S_DONE;
          end else if (exp_sr[0]) begin
            mreq.start <= 1'b1;
            mreq.x     <= acc;
            mreq.y     <= b;
            state      <= S_MULT;
          end else begin
            mreq.start <= 1'b1;
            mreq.x     <= b;
            mreq.y     <= b;
            state      <= S_SQUARE;
          end
        end
        S_MULT: begin
          if (mstat.done) begin
            acc <= mres;
            if (exp_sr[EXP_W-1:1] == '0) begin
              // last set bit, squaring would be wasted
              exp_sr <= '0;
              state  <= S_NEXT;
            end else begin
              mreq.start <= 1'b1;
              mreq.x     <= b;
              mreq.y     <= b;
              state      <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          if (mstat.done) begin
            b      <= mres;
            exp_sr <= {1'b0, exp_sr[EXP_W-1:1]};
            state  <= S_NEXT;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.power_result = out_data;

endmodule

[rtl/mme_checker.sv]
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks of the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
module mme_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [mme_pkg::MOD_W-1:0] power_result,
  input logic                      cfg_ready
);
  import mme_pkg::*;

  // one item in flight: the input closes right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("input still open after an item was accepted");

  // a new result only appears from a busy block
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result appeared without an item in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(power_result)))
    else $error("stalled result dropped or changed");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("modulus write port not ready");

endmodule

bind modular_exponentiation mme_checker u_mme_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .power_result (rsp.power_result),
  .cfg_ready    (cfg.ready)
);

[sim/tb_modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking bench for the modular exponentiation block. Operand items
// come from a queue through a valid/ready driver, and each accepted item is
// scored against a square-and-multiply predictor run at the current modulus.
// Modulus writes happen between phases once the block has drained. Sender
// and receiver gaps change from phase to phase, and one long receiver stall
// backs the block up against its input.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
  import mme_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned FINAL_CYCLES   = 40;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam logic [MOD_W-1:0] BASE_MAX  = MOD_W'(2147483646);
  localparam logic [MOD_W-1:0] MOD_MAX   = MOD_W'(2147483647);
  localparam logic [EXP_W-1:0] EXP_ONES  = '1;

  typedef struct {
    logic [MOD_W-1:0] base_value;
    logic [EXP_W-1:0] exponent;
  } operand_t;

  typedef struct {
    operand_t         op;
    logic [MOD_W-1:0] modulus;
    logic [MOD_W-1:0] power;
  } power_check_t;

  logic clk;
  logic rst;

  mme_req_if req_ch ();
  mme_rsp_if rsp_ch ();
  mme_cfg_if cfg_ch ();

  modular_exponentiation i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  operand_t         operand_q[$];
  power_check_t     power_q[$];
  logic [MOD_W-1:0] modulus_copy;
  int unsigned      send_gap_pct;
  int unsigned      recv_gap_pct;
  int unsigned      fault_count;
  int unsigned      quiet_cycles;
  int unsigned      hold_left;
  logic             pressure_arm;
  logic             pressure_done;

  always #6 clk = ~clk;

  // right-to-left square-and-multiply; 31-bit operands keep products in 62 bits
  function automatic logic [MOD_W-1:0] expected_power(logic [MOD_W-1:0] base_value,
                                                      logic [EXP_W-1:0] exponent,
                                                      logic [MOD_W-1:0] modulus);
    logic [63:0] acc;
    logic [63:0] running;
    logic [63:0] m;
    if (modulus < MOD_W'(2)) begin
      return '0;
    end
    m       = 64'(modulus);
    running = 64'(base_value) % m;
    acc     = 64'd1;
    for (int i = 0; i < EXP_W; i++) begin
      if (exponent[i]) begin
        acc = (acc * running) % m;
      end
      running = (running * running) % m;
    end
    return acc[MOD_W-1:0];
  endfunction

  function automatic logic [EXP_W-1:0] random_exponent(int unsigned max_bits);
    int unsigned width;
    logic [63:0] raw;
    width = $urandom_range(max_bits, 1);
    raw   = {$urandom, $urandom};
    raw   = raw & ((64'd1 << width) - 64'd1);
    raw[width-1] = 1'b1;
    return raw[EXP_W-1:0];
  endfunction

  task automatic note_failure(string what, power_check_t want, logic [MOD_W-1:0] got);
    if (fault_count < REPORT_LIMIT) begin
      $display("%s: base %0d exponent %0h modulus %0d expected %0d got %0d", what,
               want.op.base_value, want.op.exponent, want.modulus, want.power, got);
    end
    fault_count++;
  endtask

  task automatic push_operand(logic [MOD_W-1:0] base_value, logic [EXP_W-1:0] exponent);
    operand_t op;
    op.base_value = base_value;
    op.exponent   = exponent;
    operand_q.push_back(op);
  endtask

  task automatic push_random_operand(int unsigned max_bits);
    logic [MOD_W-1:0] base_value;
    logic [EXP_W-1:0] exponent;
    case ($urandom_range(9))
      0: base_value = '0;
      1: base_value = MOD_W'(1);
      2: base_value = modulus_copy - MOD_W'(1);
      3: base_value = (modulus_copy > BASE_MAX) ? BASE_MAX : modulus_copy;
      default: base_value = MOD_W'($urandom_range(BASE_MAX, 0));
    endcase
    case ($urandom_range(11))
      0: exponent = '0;
      1: exponent = EXP_W'(1);
      default: exponent = random_exponent(max_bits);
    endcase
    push_operand(base_value, exponent);
  endtask

  // called at a rising edge
  task automatic write_modulus(logic [MOD_W-1:0] value);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.modulus <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    modulus_copy = value;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (operand_q.size() != 0 || req_ch.valid || power_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // operand driver: valid stays up until the item is taken
  always @(posedge clk) begin
    operand_t     sent;
    power_check_t want;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        sent         = operand_q.pop_front();
        want.op      = sent;
        want.modulus = modulus_copy;
        want.power   = expected_power(sent.base_value, sent.exponent, modulus_copy);
        power_q.push_back(want);
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (operand_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          req_ch.valid      <= 1'b1;
          req_ch.base_value <= operand_q[0].base_value;
          req_ch.exponent   <= operand_q[0].exponent;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    power_check_t want;
    if (rst) begin
      rsp_ch.ready  <= 1'b0;
      hold_left     <= 0;
      pressure_done <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (power_q.size() == 0) begin
          want = '{default: '0};
          note_failure("result with nothing expected", want, rsp_ch.power_result);
        end else begin
          want = power_q.pop_front();
          if (rsp_ch.power_result !== want.power) begin
            note_failure("power_result mismatch", want, rsp_ch.power_result);
          end
        end
      end
      if (pressure_arm && !pressure_done) begin
        pressure_done <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        rsp_ch.ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.base_value = '0;
    req_ch.exponent   = '0;
    rsp_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.modulus    = '0;
    modulus_copy      = MODULUS_RESET;
    send_gap_pct      = 20;
    recv_gap_pct      = 57;
    fault_count       = 0;
    quiet_cycles      = 0;
    hold_left         = 0;
    pressure_arm      = 1'b0;
    pressure_done     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset modulus: zero exponent, zero base, bases at and above the modulus
    push_operand(MOD_W'(2), '0);
    push_operand('0, '0);
    push_operand('0, EXP_W'(5));
    push_operand(BASE_MAX, EXP_W'(1));
    push_operand(MODULUS_RESET, EXP_W'(3));
    push_operand(MODULUS_RESET + MOD_W'(5), EXP_W'(2));
    push_operand(MOD_W'(2), EXP_ONES);
    push_operand(BASE_MAX, EXP_ONES);
    push_operand(MOD_W'(1), EXP_W'(1) << (EXP_W - 1));
    push_operand(MODULUS_RESET - MOD_W'(1), EXP_W'(2));
    push_operand(MOD_W'(4), EXP_W'(MODULUS_RESET - MOD_W'(2)));
    push_operand(MOD_W'(3), EXP_W'(1));
    wait_drained();

    write_modulus(MOD_W'(2));
    push_operand(BASE_MAX, EXP_ONES);
    push_operand(MOD_W'(3), EXP_W'(5));
    push_operand('0, '0);
    wait_drained();

    write_modulus(MOD_MAX);
    push_operand(BASE_MAX, EXP_W'(2));
    push_operand(BASE_MAX, EXP_ONES);
    push_operand(MOD_W'(12345), EXP_W'({(EXP_W+1)/2{2'b01}}));
    wait_drained();

    // moduli below range give zero without a division
    write_modulus(MOD_W'(1));
    push_operand(MOD_W'(7), '0);
    push_operand(MOD_W'(7), EXP_W'(3));
    wait_drained();
    write_modulus('0);
    push_operand(MOD_W'(7), '0);
    push_operand(BASE_MAX, EXP_ONES);
    wait_drained();

    write_modulus(MOD_W'($urandom_range(MOD_MAX, 2)));
    repeat (40) push_random_operand(EXP_W);
    wait_drained();

    send_gap_pct = 57;
    recv_gap_pct = 20;
    write_modulus(MOD_W'($urandom_range(1000, 2)));
    repeat (35) push_random_operand(EXP_W);
    wait_drained();

    // no gaps; a long receiver stall first so the block backs up
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_modulus(MOD_W'($urandom_range(MOD_MAX, MOD_MAX >> 1)));
    repeat (10) push_random_operand(12);
    pressure_arm = 1'b1;
    repeat (35) push_random_operand(EXP_W);
    wait_drained();

    repeat (FINAL_CYCLES) @(posedge clk);
    while (power_q.size() != 0) begin
      note_failure("result never arrived", power_q.pop_front(), 'x);
    end
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
